// File: hdl/vog_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vog_pkg
// Shared types and constants of the voxel occupancy grid: grid geometry,
// operation codes, input and result items, and the decoded command word.
// ----------------------------------------------------------------------------
package vog_pkg;

  // Grid geometry
  localparam int GRID_SIZE = 64;
  localparam int COL_W     = 64;
  localparam int IDX_W     = 6;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int DEPTH     = 1 << ADDR_W;
  localparam int END_W     = IDX_W + 1;

  // Operation codes
  localparam logic [1:0] OP_FILL   = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_EXTENT = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic [5:0]         col_x;
    logic [5:0]         col_y;
    logic signed [15:0] z_low;
    logic signed [15:0] z_high;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic signed [15:0] z_pos;
  } in_item_t;

  typedef struct packed {
    logic       inside_res;
    logic       extent_found;
    logic [5:0] extent_first;
    logic [6:0] extent_end;
  } out_item_t;

  // Decoded command handed from the front end to the back end
  typedef struct packed {
    logic [1:0]        kind;
    logic              hit;
    logic [ADDR_W-1:0] addr;
    logic [IDX_W-1:0]  zbit;
    logic [COL_W-1:0]  mask;
  } cmd_t;

endpackage
`default_nettype wire

// File: hdl/voxel_occupancy_grid_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_occupancy_grid_unit
// Voxel occupancy grid with span fill, point query, column extent and clear.
// ----------------------------------------------------------------------------
// For fill, query and extent items the back end reads the column word from
// the column store, which has one write port and one registered read port,
// and in the next cycle modifies it, writes it back or turns it into a
// result. A clear item zeroes one column word per cycle through the store's
// write port. After reset the store is swept the same way: while the sweep
// runs full stays high and no item is accepted. Up to two items queue ahead of
// the back end and up to two results wait behind it, so either side may
// stall without stopping the other at once. Each item yields one result.
// ----------------------------------------------------------------------------
module voxel_occupancy_grid_unit (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_push,
  output logic                     in_full,
  input  wire vog_pkg::in_item_t   in_item,
  output logic                     out_empty,
  input  wire                      out_pop,
  output vog_pkg::out_item_t       out_item
);

  vog_pkg::cmd_t front_cmd;
  vog_pkg::cmd_t head_cmd;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  logic          init_busy;

  // Decline items while the store sweep after reset runs
  assign in_full = q_full || init_busy;

  vog_front u_front (
    .item (in_item),
    .cmd  (front_cmd)
  );

  vog_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push && !in_full),
    .push_cmd (front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (head_cmd)
  );

  vog_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (q_empty),
    .cmd_head  (head_cmd),
    .cmd_pop   (q_pop),
    .init_busy (init_busy),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// File: hdl/vog_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vog_front
// Classifies an input item: rounds point coordinates to cells, checks the
// grid bounds, forms the column address and builds the fill span mask.
// ----------------------------------------------------------------------------
module vog_front (
  input  wire vog_pkg::in_item_t item,
  output vog_pkg::cmd_t          cmd
);

  typedef struct packed {
    logic                      ok;
    logic [vog_pkg::IDX_W-1:0] idx;
  } cell_t;

  // Round a Q7.8 coordinate to the nearest cell, ties upward
  function automatic cell_t to_cell(input logic signed [15:0] v);
    logic [16:0]             sum;
    logic [vog_pkg::IDX_W:0] idx_w;
    cell_t                   c;
    sum   = {1'b0, v} + 17'd128;
    idx_w = sum[vog_pkg::IDX_W+8:8];
    c.ok  = !v[15] && (v[14:0] <= 15'(vog_pkg::GRID_SIZE * 256)) &&
            (idx_w < (vog_pkg::IDX_W+1)'(vog_pkg::GRID_SIZE));
    c.idx = idx_w[vog_pkg::IDX_W-1:0];
    return c;
  endfunction

  cell_t                     cx;
  cell_t                     cy;
  cell_t                     cz;
  logic                      fill_ok;
  logic [vog_pkg::COL_W-1:0] span;

  assign cx = to_cell(item.x_pos);
  assign cy = to_cell(item.y_pos);
  assign cz = to_cell(item.z_pos);

  assign fill_ok = ({1'b0, item.col_x} < (vog_pkg::IDX_W+1)'(vog_pkg::GRID_SIZE)) &&
                   ({1'b0, item.col_y} < (vog_pkg::IDX_W+1)'(vog_pkg::GRID_SIZE));

  // Mark cells whose integer height lies strictly inside the span
  always_comb begin
    for (int z = 0; z < vog_pkg::COL_W; z++) begin
      span[z] = (z < vog_pkg::GRID_SIZE) &&
                ($signed(17'(z * 256)) > $signed({item.z_low[15], item.z_low})) &&
                ($signed(17'(z * 256)) < $signed({item.z_high[15], item.z_high}));
    end
  end

  // Build the command
  always_comb begin
    cmd      = '0;
    cmd.kind = item.op;
    case (item.op)
      vog_pkg::OP_FILL: begin
        cmd.hit  = fill_ok;
        cmd.addr = {item.col_x, item.col_y};
        cmd.mask = span;
      end
      vog_pkg::OP_QUERY: begin
        cmd.hit  = cx.ok && cy.ok && cz.ok;
        cmd.addr = {cx.idx, cy.idx};
        cmd.zbit = cz.idx;
      end
      vog_pkg::OP_EXTENT: begin
        cmd.hit  = cx.ok && cy.ok;
        cmd.addr = {cx.idx, cy.idx};
      end
      default: begin
        cmd.hit = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/vog_cmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vog_cmd_queue
// Two-entry queue of decoded commands between the front and back ends.
// ----------------------------------------------------------------------------
module vog_cmd_queue (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  wire vog_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire                pop,
  output logic               empty,
  output vog_pkg::cmd_t      head
);

  vog_pkg::cmd_t ent_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    cnt_r;
  logic [1:0]    cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign head    = ent_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// File: hdl/vog_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vog_back
// Holds the column store and carries out commands: read-modify-write for
// fill, bit test for query, first/last search for extent, and the clearing
// sweep for clear and after reset. Results wait in a two-entry queue.
// ----------------------------------------------------------------------------
module vog_back (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    cmd_empty,
  input  wire vog_pkg::cmd_t     cmd_head,
  output logic                   cmd_pop,
  output logic                   init_busy,
  output logic                   out_empty,
  input  wire                    out_pop,
  output vog_pkg::out_item_t     out_item
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_CLEAR = 2'd2;

  logic [vog_pkg::COL_W-1:0]  mem [vog_pkg::DEPTH];
  logic [vog_pkg::COL_W-1:0]  rd_data_r;

  logic [1:0]                 state_r;
  logic [1:0]                 state_nxt;
  logic [vog_pkg::ADDR_W-1:0] clr_ptr_r;
  logic [vog_pkg::ADDR_W-1:0] clr_ptr_nxt;
  logic                       clr_res_r;
  logic                       clr_res_nxt;
  vog_pkg::cmd_t              cur_r;

  logic                       mem_we;
  logic [vog_pkg::ADDR_W-1:0] mem_wa;
  logic [vog_pkg::COL_W-1:0]  mem_wd;

  vog_pkg::out_item_t         res;
  logic                       res_push;
  vog_pkg::out_item_t         res_ent_r [2];
  logic                       res_wr_r;
  logic                       res_rd_r;
  logic [1:0]                 res_cnt_r;
  logic                       res_pop;

  logic [vog_pkg::IDX_W-1:0]  ext_first;
  logic [vog_pkg::END_W-1:0]  ext_end;

  assign init_busy = (state_r == ST_CLEAR) && !clr_res_r;
  assign cmd_pop   = (state_r == ST_IDLE) && !cmd_empty && (res_cnt_r != 2'd2);

  // Search the read column for its lowest and highest set cells
  always_comb begin
    ext_first = '0;
    ext_end   = '0;
    for (int z = vog_pkg::COL_W - 1; z >= 0; z--) begin
      if (rd_data_r[z]) begin
        ext_first = vog_pkg::IDX_W'(z);
      end
    end
    for (int z = 0; z < vog_pkg::COL_W; z++) begin
      if (rd_data_r[z]) begin
        ext_end = vog_pkg::END_W'(z + 1);
      end
    end
  end

  // Sequence commands
  always_comb begin
    state_nxt   = state_r;
    clr_ptr_nxt = clr_ptr_r;
    clr_res_nxt = clr_res_r;
    mem_we      = 1'b0;
    mem_wa      = cur_r.addr;
    mem_wd      = rd_data_r | cur_r.mask;
    res         = '0;
    res_push    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_pop) begin
          if (cmd_head.kind == vog_pkg::OP_CLEAR) begin
            state_nxt   = ST_CLEAR;
            clr_res_nxt = 1'b1;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_IDLE;
        res_push  = 1'b1;
        case (cur_r.kind)
          vog_pkg::OP_FILL: begin
            mem_we = cur_r.hit;
          end
          vog_pkg::OP_QUERY: begin
            res.inside_res = cur_r.hit && rd_data_r[cur_r.zbit];
          end
          vog_pkg::OP_EXTENT: begin
            if (cur_r.hit && (rd_data_r != '0)) begin
              res.extent_found = 1'b1;
              res.extent_first = ext_first;
              res.extent_end   = ext_end;
            end
          end
          default: begin
            res = '0;
          end
        endcase
      end
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_wa      = clr_ptr_r;
        mem_wd      = '0;
        clr_ptr_nxt = clr_ptr_r + vog_pkg::ADDR_W'(1);
        if (clr_ptr_r == vog_pkg::ADDR_W'(vog_pkg::DEPTH - 1)) begin
          state_nxt   = ST_IDLE;
          clr_ptr_nxt = '0;
          clr_res_nxt = 1'b0;
          res_push    = clr_res_r;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold control state; sweep the store after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_ptr_r <= '0;
      clr_res_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_ptr_r <= clr_ptr_nxt;
      clr_res_r <= clr_res_nxt;
    end
  end

  // Latch the command being worked on
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_r <= cmd_head;
    end
  end

  // Column store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd_pop) begin
      rd_data_r <= mem[cmd_head.addr];
    end
  end

  // Result queue
  assign out_empty = (res_cnt_r == 2'd0);
  assign out_item  = res_ent_r[res_rd_r];
  assign res_pop   = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wr_r  <= 1'b0;
      res_rd_r  <= 1'b0;
      res_cnt_r <= 2'd0;
    end else begin
      if (res_push) begin
        res_wr_r <= !res_wr_r;
      end
      if (res_pop) begin
        res_rd_r <= !res_rd_r;
      end
      if (res_push && !res_pop) begin
        res_cnt_r <= res_cnt_r + 2'd1;
      end else if (res_pop && !res_push) begin
        res_cnt_r <= res_cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_ent_r[res_wr_r] <= res;
    end
  end

  // Checks
  a_ptr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CLEAR) |-> (clr_ptr_r == '0))
    else $error("clear pointer moved outside the sweep");

  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (res_cnt_r != 2'd2) || res_pop)
    else $error("result pushed into a full queue");

  a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> (state_r == ST_IDLE))
    else $error("read step did not finish in one cycle");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !cmd_pop)
    else $error("command taken while another is in progress");

endmodule
`default_nettype wire

// File: dv/voxel_occupancy_grid_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_occupancy_grid_unit_tb
// Self-checking bench for the voxel occupancy grid. A short table of
// directed items covers the edges of the coordinate range, rounding ties,
// empty and inverted spans, full columns and clear. Random traffic follows,
// aimed mostly at a small pool of columns so that queries and extents hit
// filled voxels. Each result is compared with a typed row's value or a shadow grid.
// ----------------------------------------------------------------------------
module voxel_occupancy_grid_unit_tb;
  import vog_pkg::*;

  localparam int RANDOM_ITEMS = 1875;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 20;
  localparam int POOL_SIZE    = 8;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t res;
  } stim_row_t;

  localparam out_item_t NO_RESULT   = '0;
  localparam out_item_t FULL_COLUMN = '{inside_res: 1'b0, extent_found: 1'b1,
                                        extent_first: 6'd0, extent_end: 7'd64};

  logic      clk;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_item_t  in_item;
  logic      out_empty;
  logic      out_pop;
  out_item_t out_item;

  // Shadow grid and the results it predicts
  logic [COL_W-1:0] grid_shadow [0:DEPTH-1];
  out_item_t        pending_results [$];
  stim_row_t        directed_rows [$];
  int               pool_x [POOL_SIZE];
  int               pool_y [POOL_SIZE];

  int cycles;
  int results_seen;
  int mismatches;
  int n_fill, n_query, n_extent, n_clear, n_hits, n_found;

  voxel_occupancy_grid_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Round a Q7.8 coordinate to a cell; 0 when it falls outside the grid
  function automatic bit cell_of(input logic signed [15:0] v, output int idx);
    int vi;
    vi = v;
    idx = 0;
    if (vi < 0 || vi > GRID_SIZE * 256) return 1'b0;
    idx = (vi + 128) >>> 8;
    return idx < GRID_SIZE;
  endfunction

  // Apply one item to the shadow grid and return the result it produces
  function automatic out_item_t grid_apply(input in_item_t it);
    out_item_t r;
    int cx, cy, cz, pos;
    logic [COL_W-1:0] col;
    r = NO_RESULT;
    case (it.op)
      OP_FILL: begin
        n_fill++;
        for (int z = 0; z < GRID_SIZE; z++) begin
          pos = z * 256;
          if (pos > int'(it.z_low) && pos < int'(it.z_high))
            grid_shadow[{it.col_x, it.col_y}][z] = 1'b1;
        end
      end
      OP_QUERY: begin
        n_query++;
        if (cell_of(it.x_pos, cx) && cell_of(it.y_pos, cy) && cell_of(it.z_pos, cz))
          r.inside_res = grid_shadow[{cx[5:0], cy[5:0]}][cz];
      end
      OP_EXTENT: begin
        n_extent++;
        if (cell_of(it.x_pos, cx) && cell_of(it.y_pos, cy)) begin
          col = grid_shadow[{cx[5:0], cy[5:0]}];
          if (col != '0) begin
            r.extent_found = 1'b1;
            for (int z = GRID_SIZE - 1; z >= 0; z--)
              if (col[z]) r.extent_first = z[5:0];
            for (int z = 0; z < GRID_SIZE; z++)
              if (col[z]) r.extent_end = 7'(z + 1);
          end
        end
      end
      default: begin
        n_clear++;
        for (int a = 0; a < DEPTH; a++) grid_shadow[a] = '0;
      end
    endcase
    return r;
  endfunction

  function automatic in_item_t fill_item(input int cx, input int cy,
                                         input int zl, input int zh);
    in_item_t it;
    it = '0;
    it.op     = OP_FILL;
    it.col_x  = cx[5:0];
    it.col_y  = cy[5:0];
    it.z_low  = 16'(zl);
    it.z_high = 16'(zh);
    return it;
  endfunction

  function automatic in_item_t point_item(input logic [1:0] op, input int x,
                                          input int y, input int z);
    in_item_t it;
    it = '0;
    it.op    = op;
    it.x_pos = 16'(x);
    it.y_pos = 16'(y);
    it.z_pos = 16'(z);
    return it;
  endfunction

  function automatic void add_row(input in_item_t it, input bit typed,
                                  input out_item_t res);
    stim_row_t row;
    row.item  = it;
    row.typed = typed;
    row.res   = res;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // Coordinate around a cell center, with the odd edge or wild value
  function automatic logic signed [15:0] near_coord(input int ctr);
    case ($urandom_range(0, 19))
      0:       return 16'($urandom);
      1:       case ($urandom_range(0, 5))
                 0:       return 16'sd0;
                 1:       return 16'sd127;
                 2:       return 16'sd128;
                 3:       return 16'sd16255;
                 4:       return 16'sd16256;
                 default: return 16'sd16384;
               endcase
      default: return 16'(ctr * 256 + int'($urandom_range(0, 255)) - 128);
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    logic [95:0] raw;
    int sel, slot, cx, cy, zl;
    raw  = {$urandom, $urandom, $urandom};
    it   = raw[$bits(in_item_t)-1:0];
    sel  = $urandom_range(0, 199);
    slot = $urandom_range(0, POOL_SIZE - 1);
    if ($urandom_range(0, 4) == 0) begin
      cx = $urandom_range(0, 63);
      cy = $urandom_range(0, 63);
    end else begin
      cx = pool_x[slot];
      cy = pool_y[slot];
    end
    if (sel < 2) begin
      it.op = OP_CLEAR;
    end else if (sel < 72) begin
      it.op    = OP_FILL;
      it.col_x = cx[5:0];
      it.col_y = cy[5:0];
      // mostly spans of a few cells near the grid, some left fully random
      if ($urandom_range(0, 9) != 0) begin
        zl        = int'($urandom_range(0, 17408)) - 512;
        it.z_low  = 16'(zl);
        it.z_high = 16'(zl + int'($urandom_range(0, 4096)) - 256);
      end
    end else if (sel < 142) begin
      it.op    = OP_QUERY;
      it.x_pos = near_coord(cx);
      it.y_pos = near_coord(cy);
      it.z_pos = near_coord($urandom_range(0, 63));
    end else begin
      it.op    = OP_EXTENT;
      it.x_pos = near_coord(cx);
      it.y_pos = near_coord(cy);
    end
    return it;
  endfunction

  // Offer one item at the falling edge and hold it until accepted
  task automatic offer_item(input in_item_t it, input bit typed, input out_item_t res);
    out_item_t predicted;
    in_item <= it;
    in_push <= 1'b1;
    forever begin
      @(posedge clk);
      if (!in_full) break;
      @(negedge clk);
    end
    predicted = grid_apply(it);
    pending_results.insert(pending_results.size(), typed ? res : predicted);
    @(negedge clk);
  endtask

  // Now and then drop push for a random gap, except when quiet
  task automatic maybe_idle(input bit quiet);
    if (!quiet && $urandom_range(0, 99) < 10) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  // Check each popped result against the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    cycles <= cycles + 1;
    if (rst_n && out_pop && !out_empty) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result at cycle %0d: %p", cycles, out_item);
      end else begin
        want = pending_results.pop_front();
        if (want.inside_res) n_hits++;
        if (want.extent_found) n_found++;
        if (out_item.inside_res !== want.inside_res ||
            out_item.extent_found !== want.extent_found ||
            out_item.extent_first !== want.extent_first ||
            out_item.extent_end !== want.extent_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display(
              "result %0d exp/act: inside %0b/%0b found %0b/%0b first %0d/%0d end %0d/%0d",
              results_seen, want.inside_res, out_item.inside_res,
              want.extent_found, out_item.extent_found,
              want.extent_first, out_item.extent_first,
              want.extent_end, out_item.extent_end);
        end
      end
    end
  end

  // Receiver: random stalls, a quiet stretch and one long hold-off
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_pop   = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= 300) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (results_seen >= 700 && results_seen < 1000) begin
        out_pop <= 1'b1;
      end else begin
        out_pop <= ($urandom_range(0, 99) >= 10);
      end
    end
  end

  // Give up if the run stalls
  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results waiting", cycles,
             pending_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // Sender: reset, directed table, random traffic, drain
  initial begin
    int sent;
    cycles       = 0;
    results_seen = 0;
    mismatches   = 0;
    n_fill = 0; n_query = 0; n_extent = 0; n_clear = 0; n_hits = 0; n_found = 0;
    rst_n   = 1'b0;
    in_push = 1'b0;
    in_item = '0;
    for (int a = 0; a < DEPTH; a++) grid_shadow[a] = '0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_x[i] = $urandom_range(0, 63);
      pool_y[i] = $urandom_range(0, 63);
    end

    // empty grid, full column, range edges, rounding, spans, clear
    add_row(point_item(OP_QUERY, 0, 0, 0), 1'b1, NO_RESULT);
    add_row(point_item(OP_EXTENT, 0, 0, 0), 1'b1, NO_RESULT);
    add_row(fill_item(0, 0, -32768, 32767), 1'b1, NO_RESULT);
    add_row(point_item(OP_EXTENT, 0, 0, 0), 1'b1, FULL_COLUMN);
    add_row(point_item(OP_QUERY, 0, 0, 16255), 1'b0, NO_RESULT);
    add_row(point_item(OP_QUERY, 0, 0, 16256), 1'b1, NO_RESULT);
    add_row(point_item(OP_QUERY, 0, 0, 16384), 1'b1, NO_RESULT);
    add_row(point_item(OP_QUERY, 0, 0, -1), 1'b1, NO_RESULT);
    add_row(point_item(OP_QUERY, 127, 0, 128), 1'b0, NO_RESULT);
    add_row(fill_item(63, 63, 2560, 2560), 1'b1, NO_RESULT);
    add_row(fill_item(63, 63, 5000, 1000), 1'b1, NO_RESULT);
    add_row(point_item(OP_EXTENT, 16128, 16128, 0), 1'b0, NO_RESULT);
    add_row(fill_item(63, 63, 2560, 2561), 1'b1, NO_RESULT);
    add_row(fill_item(63, 63, 2559, 2817), 1'b1, NO_RESULT);
    add_row(point_item(OP_EXTENT, 16255, 16000, 0), 1'b0, NO_RESULT);
    add_row(fill_item(1, 2, 16127, 32767), 1'b1, NO_RESULT);
    add_row(point_item(OP_EXTENT, 256, 512, 0), 1'b0, NO_RESULT);
    add_row(point_item(OP_QUERY, 32767, 0, 0), 1'b1, NO_RESULT);
    add_row(point_item(OP_QUERY, -32768, 0, 0), 1'b1, NO_RESULT);
    add_row(point_item(OP_CLEAR, 0, 0, 0), 1'b1, NO_RESULT);
    add_row(point_item(OP_EXTENT, 0, 0, 0), 1'b1, NO_RESULT);
    add_row(point_item(OP_QUERY, 16128, 16128, 2560), 1'b1, NO_RESULT);
    add_row(fill_item(32, 21, -32768, 0), 1'b0, NO_RESULT);
    add_row(fill_item(42, 21, -1, 1), 1'b0, NO_RESULT);
    add_row(point_item(OP_QUERY, 10752, 5376, 0), 1'b0, NO_RESULT);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      maybe_idle(1'b0);
      offer_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].res);
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      // once, drain everything before going on
      if (sent == 1300) begin
        in_push <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0) @(negedge clk);
      end
      // move the column pool now and then
      if (sent % 150 == 149) begin
        pool_x[$urandom_range(0, POOL_SIZE - 1)] = $urandom_range(0, 63);
        pool_y[$urandom_range(0, POOL_SIZE - 1)] = $urandom_range(0, 63);
      end
      maybe_idle(sent >= 700 && sent < 1000);
      offer_item(random_item(), 1'b0, NO_RESULT);
      sent++;
    end
    in_push <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d items: %0d fill, %0d query (%0d hit), %0d extent (%0d found), %0d clear",
             n_fill + n_query + n_extent + n_clear, n_fill, n_query, n_hits,
             n_extent, n_found, n_clear);
    $display("%0d results checked in %0d cycles, %0d mismatches",
             results_seen, cycles, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: voxel_occupancy_grid_unit.f
hdl/vog_pkg.sv
hdl/vog_front.sv
hdl/vog_cmd_queue.sv
hdl/vog_back.sv
hdl/voxel_occupancy_grid_unit.sv
dv/voxel_occupancy_grid_unit_tb.sv
